[rtl/bft_pkg.sv]
// Shared types and constants of the bidirectional flow tracker.
`default_nettype none

package bft_pkg;

    localparam int unsigned ADDR_W       = 32;
    localparam int unsigned PORT_W       = 16;
    // Table size is fixed by the width of the flow index on the output.
    localparam int unsigned FLOW_ENTRIES = 64;
    localparam int unsigned FLOW_INDEX_W = 6;

    // One packet's 4-tuple as it arrives on the input channel.
    typedef struct packed {
        logic [ADDR_W-1:0] src_addr;
        logic [PORT_W-1:0] src_port;
        logic [ADDR_W-1:0] dst_addr;
        logic [PORT_W-1:0] dst_port;
    } t_in_item;

    // One lookup result as it leaves on the output channel.
    typedef struct packed {
        logic [FLOW_INDEX_W-1:0] flow_index;
        logic                    direction_swapped;
        logic                    reverse_direction;
        logic                    entry_created;
        logic                    table_full;
    } t_out_item;

    // Lookup token handed from cell to cell; its valid bit travels beside it.
    typedef struct packed {
        logic      done;
        t_in_item  tuple;
        t_out_item res;
    } t_token;

endpackage

`default_nettype wire

[rtl/bft_cell.sv]
// One flow table entry: compares, updates or claims as the lookup token passes.
`default_nettype none

module bft_cell #(
    parameter int unsigned CELL_INDEX = 0,
    parameter int unsigned COUNT_W    = 7
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    input  wire bft_pkg::t_token    i_tok,
    input  wire logic [COUNT_W-1:0] i_flows_in_use,
    output logic                    o_valid,
    output bft_pkg::t_token         o_tok
);
    import bft_pkg::*;

    localparam logic [COUNT_W-1:0]      CELL_COUNT_C = COUNT_W'(CELL_INDEX);
    localparam logic [FLOW_INDEX_W-1:0] CELL_IDX_C   = FLOW_INDEX_W'(CELL_INDEX);

    logic [ADDR_W-1:0] r_src_addr;
    logic [PORT_W-1:0] r_src_port;
    logic [ADDR_W-1:0] r_dst_addr;
    logic [PORT_W-1:0] r_dst_port;
    logic              r_rev;
    logic              n_rev;
    logic              n_wr;
    logic              r_valid;
    t_token            r_tok;
    t_token            n_tok;
    logic              occupied;
    logic              at_free;
    logic              fwd_hit;
    logic              bwd_hit;

    assign occupied = CELL_COUNT_C < i_flows_in_use;
    assign at_free  = CELL_COUNT_C == i_flows_in_use;

    assign fwd_hit = (r_src_addr == i_tok.tuple.src_addr) &&
                     (r_src_port == i_tok.tuple.src_port) &&
                     (r_dst_addr == i_tok.tuple.dst_addr) &&
                     (r_dst_port == i_tok.tuple.dst_port);
    assign bwd_hit = (r_src_addr == i_tok.tuple.dst_addr) &&
                     (r_src_port == i_tok.tuple.dst_port) &&
                     (r_dst_addr == i_tok.tuple.src_addr) &&
                     (r_dst_port == i_tok.tuple.src_port);

    always_comb begin
        n_tok = i_tok;
        n_rev = r_rev;
        n_wr  = 1'b0;
        if (i_valid && !i_tok.done) begin
            if (occupied && (fwd_hit || bwd_hit)) begin
                // stored orientation wins when both match
                n_tok.done                  = 1'b1;
                n_tok.res.flow_index        = CELL_IDX_C;
                n_tok.res.reverse_direction = !fwd_hit;
                n_tok.res.direction_swapped = r_rev != !fwd_hit;
                n_tok.res.entry_created     = 1'b0;
                n_tok.res.table_full        = 1'b0;
                n_rev                       = !fwd_hit;
            end else if (at_free) begin
                // first free entry: claim it in forward orientation
                n_tok.done                  = 1'b1;
                n_tok.res.flow_index        = CELL_IDX_C;
                n_tok.res.reverse_direction = 1'b0;
                n_tok.res.direction_swapped = 1'b0;
                n_tok.res.entry_created     = 1'b1;
                n_tok.res.table_full        = 1'b0;
                n_rev                       = 1'b0;
                n_wr                        = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_tok <= n_tok;
        r_rev <= n_rev;
        if (n_wr) begin
            r_src_addr <= i_tok.tuple.src_addr;
            r_src_port <= i_tok.tuple.src_port;
            r_dst_addr <= i_tok.tuple.dst_addr;
            r_dst_port <= i_tok.tuple.dst_port;
        end
    end

    assign o_valid = r_valid;
    assign o_tok   = r_tok;

endmodule

`default_nettype wire

[rtl/bidirectional_flow_tracker_unit.sv]
// Top level of the bidirectional flow tracker: cell chain, occupancy count, result register.
`default_nettype none

// Bidirectional flow tracker. Each accepted transaction carries one TCP/IPv4
// 4-tuple. The tuple is looked up among the occupied flow entries, lowest
// index first, in stored orientation and then reversed; a hit reports the
// entry index, whether the packet runs against the orientation stored at
// creation, and whether its direction differs from the flow's previous
// packet. A miss appends the tuple at the next free entry in forward
// orientation, or reports table full (index zero, nothing stored) when all
// FLOW_ENTRIES entries are taken. The table is a chain of FLOW_ENTRIES
// identical cells, one entry per cell; a lookup token walks the chain one
// cell per clock, and its result is then registered before it is presented.
// One lookup is in flight at a time: the input stalls from acceptance until
// the result transaction has been taken, so a new transaction is accepted
// only after the previous result has gone. No clearing pass is needed after
// reset; the entry contents stay undefined and only entries below the
// occupancy count are ever compared.
module bidirectional_flow_tracker_unit (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire bft_pkg::t_in_item  i_in_data,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output bft_pkg::t_out_item      o_out_data
);
    import bft_pkg::*;

    localparam int unsigned COUNT_W = $clog2(FLOW_ENTRIES + 1);
    localparam logic [COUNT_W-1:0] FULL_COUNT_C = COUNT_W'(FLOW_ENTRIES);

    // token taps between cells: tap 0 feeds the first cell, the last tap
    // leaves the final cell
    logic   w_valid [FLOW_ENTRIES+1];
    t_token w_tok   [FLOW_ENTRIES+1];

    logic               r_busy;
    logic               r_out_valid;
    t_out_item          r_out;
    t_out_item          n_out;
    logic [COUNT_W-1:0] r_flows_in_use;
    logic               in_accept;
    logic               out_accept;
    logic               tail_valid;
    t_token             tail_tok;

    assign in_accept  = i_in_valid && !r_busy;
    assign out_accept = r_out_valid && !i_out_stall;

    // Launch a fresh token: nothing found yet, result cleared.
    assign w_valid[0] = in_accept;
    always_comb begin
        w_tok[0]       = '0;
        w_tok[0].tuple = i_in_data;
    end

    for (genvar g = 0; g < FLOW_ENTRIES; g++) begin : g_cell
        bft_cell #(
            .CELL_INDEX (g),
            .COUNT_W    (COUNT_W)
        ) u_cell (
            .i_clk          (i_clk),
            .i_rst_n        (i_rst_n),
            .i_valid        (w_valid[g]),
            .i_tok          (w_tok[g]),
            .i_flows_in_use (r_flows_in_use),
            .o_valid        (w_valid[g+1]),
            .o_tok          (w_tok[g+1])
        );
    end

    assign tail_valid = w_valid[FLOW_ENTRIES];
    assign tail_tok   = w_tok[FLOW_ENTRIES];

    // A token that leaves the chain unresolved found no match and no free
    // entry: report table full with index zero.
    always_comb begin
        if (tail_tok.done) begin
            n_out = tail_tok.res;
        end else begin
            n_out            = '0;
            n_out.table_full = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy         <= 1'b0;
            r_out_valid    <= 1'b0;
            r_flows_in_use <= '0;
        end else begin
            // hold off new transactions until the result has gone
            if (in_accept) begin
                r_busy <= 1'b1;
            end else if (out_accept) begin
                r_busy <= 1'b0;
            end

            if (tail_valid) begin
                r_out_valid <= 1'b1;
            end else if (out_accept) begin
                r_out_valid <= 1'b0;
            end

            // advance the occupancy count once the claiming token has left
            if (tail_valid && tail_tok.done && tail_tok.res.entry_created) begin
                r_flows_in_use <= r_flows_in_use + COUNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (tail_valid) begin
            r_out <= n_out;
        end
    end

    assign o_in_stall  = r_busy;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // The occupancy count never passes the table size.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_flows_in_use <= FULL_COUNT_C)
        else $error("flow occupancy count beyond table size");

    // Table full is only reported when every entry is occupied.
    a_full_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.table_full) |-> (r_flows_in_use == FULL_COUNT_C))
        else $error("table full reported with free entries");

    // A result never both creates an entry and reports the table full.
    a_create_excl_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_out_data.entry_created && o_out_data.table_full))
        else $error("entry created and table full together");

    // A token never reaches the end of the chain while a result still waits.
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        tail_valid |-> !r_out_valid)
        else $error("lookup finished while previous result pending");

    // A new entry grows the count by exactly one on the following cycle.
    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (tail_valid && tail_tok.done && tail_tok.res.entry_created)
            |=> (r_flows_in_use == $past(r_flows_in_use) + COUNT_W'(1)))
        else $error("occupancy count did not advance on entry creation");

endmodule

`default_nettype wire
